@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check themselves.
// No dependencies; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fh64_pkg.sv @@
// fasthash64 shared constants, operand select codes and controller/datapath structs.
// No dependencies.
package fh64_pkg;

    localparam logic [63:0] HASH_MUL_M = 64'h880355f21e6d1965;
    localparam logic [63:0] MIX_MUL    = 64'h2127599bf4325c37;
    localparam logic [63:0] SEED_RESET = 64'h7766554433221100;
    localparam int unsigned MIX_SHIFT_A = 23;
    localparam int unsigned MIX_SHIFT_B = 47;

    localparam logic [1:0] SEL_LEN  = 2'd0;
    localparam logic [1:0] SEL_WORD = 2'd1;
    localparam logic [1:0] SEL_ACC  = 2'd2;
    localparam logic [1:0] SEL_FIN  = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       acc_len;
        logic       acc_prod;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic first;
        logic nonzero;
        logic last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/fh64_mul.sv @@
// Iterative 64x64 multiplier, low 64 bits of the product, one 32x32 partial per cycle.
// Depends on nothing; used by fh64_datapath.
module fh64_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  step_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] pp_next;
    logic [63:0] acc_next;

    assign op_a    = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign op_b    = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign pp_next = {32'b0, op_a} * {32'b0, op_b};

    always_comb
    begin
        acc_next = acc_reg;
        case (step_reg)
            2'd0:    acc_next = acc_reg;
            2'd1:    acc_next = pp_reg;
            default: acc_next = {acc_reg[63:32] + pp_reg[31:0], acc_reg[31:0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (run_reg)
        begin
            pp_reg  <= pp_next;
            acc_reg <= acc_next;
        end
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/fh64_datapath.sv @@
// fasthash64 datapath: input latch, seed, accumulator, mix logic and result register.
// Depends on fh64_pkg and fh64_mul.
module fh64_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  fh64_pkg::cmd_t  cmd,
    output fh64_pkg::stat_t stat,
    input  logic [63:0]     in_word,
    input  logic [3:0]      in_count,
    input  logic            in_first,
    input  logic            in_last,
    input  logic [31:0]     in_len,
    input  logic            cfg_we,
    input  logic [63:0]     cfg_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     out_hash
);

    logic [63:0] seed_reg;
    logic [63:0] acc_reg;
    logic [63:0] word_reg;
    logic [31:0] len_reg;
    logic        first_reg;
    logic        nz_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [63:0] hash_reg;
    logic [63:0] masked;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] prod;
    logic [63:0] prod_mixed;
    logic        mul_busy;
    logic        mul_done;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked[i*8 +: 8] = (in_count[3] || (in_count[2:0] > 3'(i)))
                             ? in_word[i*8 +: 8] : 8'h00;
        end
    end

    assign prod_mixed = prod ^ (prod >> fh64_pkg::MIX_SHIFT_B);

    always_comb
    begin
        mul_a = {32'b0, len_reg};
        mul_b = fh64_pkg::HASH_MUL_M;
        case (cmd.mul_sel)
            fh64_pkg::SEL_LEN:
            begin
                mul_a = {32'b0, len_reg};
                mul_b = fh64_pkg::HASH_MUL_M;
            end
            fh64_pkg::SEL_WORD:
            begin
                mul_a = word_reg ^ (word_reg >> fh64_pkg::MIX_SHIFT_A);
                mul_b = fh64_pkg::MIX_MUL;
            end
            fh64_pkg::SEL_ACC:
            begin
                mul_a = acc_reg ^ prod_mixed;
                mul_b = fh64_pkg::HASH_MUL_M;
            end
            default:
            begin
                mul_a = acc_reg ^ (acc_reg >> fh64_pkg::MIX_SHIFT_A);
                mul_b = fh64_pkg::MIX_MUL;
            end
        endcase
    end

    fh64_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= fh64_pkg::SEED_RESET;
            acc_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            nz_reg        <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_data;
            if (cmd.acc_len)
                acc_reg <= seed_reg ^ prod;
            else if (cmd.acc_prod)
                acc_reg <= prod;
            if (cmd.load_in)
            begin
                first_reg <= in_first;
                nz_reg    <= (in_count != 4'd0);
                last_reg  <= in_last;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            word_reg <= masked;
            len_reg  <= in_len;
        end
        if (cmd.out_load)
            hash_reg <= prod_mixed;
    end

    assign stat.mul_busy = mul_busy;
    assign stat.mul_done = mul_done;
    assign stat.first    = first_reg;
    assign stat.nonzero  = nz_reg;
    assign stat.last     = last_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hash  = hash_reg;

endmodule

@@ rtl/fh64_ctrl.sv @@
// fasthash64 controller: sequences the multiplies for one input transfer.
// Depends on fh64_pkg.
module fh64_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output fh64_pkg::cmd_t  cmd,
    input  fh64_pkg::stat_t stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PLAN = 4'd1;
    localparam logic [3:0] S_LEN  = 4'd2;
    localparam logic [3:0] S_MIDW = 4'd3;
    localparam logic [3:0] S_WORD = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_sel   = fh64_pkg::SEL_LEN;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (stat.first)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fh64_pkg::SEL_LEN;
                    state_next    = S_LEN;
                end
                else
                    state_next = S_MIDW;
            end
            S_LEN:
            begin
                if (stat.mul_done)
                begin
                    cmd.acc_len = 1'b1;
                    state_next  = S_MIDW;
                end
            end
            S_MIDW:
            begin
                if (stat.nonzero)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fh64_pkg::SEL_WORD;
                    state_next    = S_WORD;
                end
                else
                    state_next = S_TAIL;
            end
            S_WORD:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fh64_pkg::SEL_ACC;
                    state_next    = S_ACC;
                end
            end
            S_ACC:
            begin
                if (stat.mul_done)
                begin
                    cmd.acc_prod = 1'b1;
                    state_next   = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (stat.last)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fh64_pkg::SEL_FIN;
                    state_next    = S_FIN;
                end
                else
                    state_next = S_IDLE;
            end
            S_FIN:
            begin
                if (stat.mul_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/fasthash64_stream.sv @@
// Channel   Signals                          Content
// s_*       s_tvalid s_tready s_tdata ...    message words, tuser = first, tlast = last
// m_*       m_tvalid m_tready m_tdata        64-bit hash per message
// cfg_*     cfg_valid cfg_ready cfg_data     seed write
//
// Each multiply runs on one shared 32x32 unit.
// A transfer runs up to four multiplies (length, word mix, accumulator, final mix), plus
// a hash load on a last transfer; input is taken only when idle.
// Reset loads the default seed and clears the accumulator; the result register
// holds while m_tready is low and the next transfer is still accepted meanwhile.
// Top level; depends on fh64_pkg, fh64_ctrl, fh64_datapath, assert_macros.svh.
`include "assert_macros.svh"
module fasthash64_stream
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // data_word[63:0], byte_count[67:64], message_length[99:68]
    input  logic         s_tuser,   // first_item
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // hash_value[63:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);

    fh64_pkg::cmd_t  cmd;
    fh64_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fh64_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fh64_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_tdata[63:0]),
        .in_count  (s_tdata[67:64]),
        .in_first  (s_tuser),
        .in_last   (s_tlast),
        .in_len    (s_tdata[99:68]),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (m_tdata)
    );

    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `ASSERT_IMPL(a_mul_no_restart, clk, rst_n, cmd.mul_start, !stat.mul_busy, "multiplier restarted")
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !m_tvalid || m_tready, "pending hash lost")

endmodule
